[src/ufe_pkg.sv]
// Shared types and constants for the union-find engine.
// No dependencies; used by every module under src except ufe_ram.
package ufe_pkg;

  localparam int unsigned MAX_NODES_DEF = 1024;
  localparam int unsigned NODE_W        = 10;
  localparam int unsigned SIZE_W        = 11;
  localparam int unsigned RED_STEPS     = 10;
  localparam int unsigned RED_K_W       = 4;
  localparam int unsigned RED_W         = NODE_W + RED_STEPS;

  localparam logic OP_FIND  = 1'b0;
  localparam logic OP_UNION = 1'b1;

  typedef struct packed {
    logic              op;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
  } ufe_cmd_t;

  typedef struct packed {
    logic [NODE_W-1:0] root;
    logic              already_joined;
    logic [SIZE_W-1:0] set_size;
  } ufe_result_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RED,
    ST_FIND_START,
    ST_WALK,
    ST_CMP,
    ST_NEXT,
    ST_SZ_A,
    ST_SZ_B,
    ST_JOIN,
    ST_FINISH
  } ufe_state_t;

endpackage

[src/ufe_ram.sv]
// Simple dual-port RAM: one write and one registered read per cycle.
// No package dependency; holds the parent and size tables.
module ufe_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned W     = 10
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[src/ufe_alu.sv]
// Set-size compare and add unit shared by every union.
// Depends on ufe_pkg for the size width.
module ufe_alu (
  input  logic [ufe_pkg::SIZE_W-1:0] a,
  input  logic [ufe_pkg::SIZE_W-1:0] b,
  output logic                       lt,
  output logic [ufe_pkg::SIZE_W-1:0] sum
);

  assign lt  = a < b;
  assign sum = a + b;

endmodule

[src/ufe_ctrl.sv]
// Sequencer for find and union: table clearing, optional index reduction, root walk,
// path compression, size merge. Depends on ufe_pkg, ufe_ram and ufe_alu.
module ufe_ctrl #(
  parameter int unsigned MAX_NODES = ufe_pkg::MAX_NODES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  ufe_pkg::ufe_cmd_t    cmd,
  output logic                 res_valid,
  input  logic                 res_ready,
  output ufe_pkg::ufe_result_t res
);

  localparam int unsigned IW = $clog2(MAX_NODES);
  localparam bit DO_RED = (MAX_NODES < 1024) && ((MAX_NODES & (MAX_NODES - 1)) != 0);

  ufe_pkg::ufe_state_t state_r, state_nxt;

  logic [IW-1:0]                  clr_r, clr_nxt;
  logic                           op_r, op_nxt;
  logic [ufe_pkg::NODE_W-1:0]     a_r, a_nxt, b_r, b_nxt;
  logic                           second_r, second_nxt;
  logic [ufe_pkg::RED_K_W-1:0]    red_k_r, red_k_nxt;
  logic [IW-1:0]                  start_r, start_nxt;
  logic [IW-1:0]                  cur_r, cur_nxt;
  logic [IW-1:0]                  top_r, top_nxt;
  logic [IW-1:0]                  ra_r, ra_nxt;
  logic [ufe_pkg::SIZE_W-1:0]     size_a_r, size_a_nxt;
  logic [IW-1:0]                  res_root_r, res_root_nxt;
  logic                           joined_r, joined_nxt;
  logic [ufe_pkg::SIZE_W-1:0]     res_size_r, res_size_nxt;

  logic                           par_we;
  logic [IW-1:0]                  par_waddr, par_wdata, par_raddr, par_rdata;
  logic                           siz_we;
  logic [IW-1:0]                  siz_waddr, siz_raddr;
  logic [ufe_pkg::SIZE_W-1:0]     siz_wdata, siz_rdata;

  logic                           alu_lt;
  logic [ufe_pkg::SIZE_W-1:0]     alu_sum;

  logic [IW-1:0]                  start_sel;
  logic [ufe_pkg::RED_W-1:0]      red_sub, a_ext, b_ext;

  assign start_sel = second_r ? IW'(b_r) : IW'(a_r);
  assign red_sub   = ufe_pkg::RED_W'(MAX_NODES) << red_k_r;
  assign a_ext     = ufe_pkg::RED_W'(a_r);
  assign b_ext     = ufe_pkg::RED_W'(b_r);

  ufe_ram #(.DEPTH(MAX_NODES), .W(IW)) u_parent (
    .clk   (clk),
    .we    (par_we),
    .waddr (par_waddr),
    .wdata (par_wdata),
    .raddr (par_raddr),
    .rdata (par_rdata)
  );

  ufe_ram #(.DEPTH(MAX_NODES), .W(ufe_pkg::SIZE_W)) u_size (
    .clk   (clk),
    .we    (siz_we),
    .waddr (siz_waddr),
    .wdata (siz_wdata),
    .raddr (siz_raddr),
    .rdata (siz_rdata)
  );

  ufe_alu u_alu (
    .a   (size_a_r),
    .b   (siz_rdata),
    .lt  (alu_lt),
    .sum (alu_sum)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ufe_pkg::ST_CLEAR: begin
        if (clr_r == IW'(MAX_NODES - 1)) state_nxt = ufe_pkg::ST_IDLE;
      end
      ufe_pkg::ST_IDLE: begin
        if (cmd_valid) state_nxt = DO_RED ? ufe_pkg::ST_RED : ufe_pkg::ST_FIND_START;
      end
      ufe_pkg::ST_RED: begin
        if (red_k_r == '0) state_nxt = ufe_pkg::ST_FIND_START;
      end
      ufe_pkg::ST_FIND_START: state_nxt = ufe_pkg::ST_WALK;
      ufe_pkg::ST_WALK: begin
        if (par_rdata == cur_r) begin
          state_nxt = (start_r == cur_r) ? ufe_pkg::ST_NEXT : ufe_pkg::ST_CMP;
        end
      end
      ufe_pkg::ST_CMP: begin
        if (par_rdata == top_r) state_nxt = ufe_pkg::ST_NEXT;
      end
      ufe_pkg::ST_NEXT: begin
        if (!second_r && op_r == ufe_pkg::OP_UNION) state_nxt = ufe_pkg::ST_FIND_START;
        else                                         state_nxt = ufe_pkg::ST_SZ_A;
      end
      ufe_pkg::ST_SZ_A:   state_nxt = ufe_pkg::ST_SZ_B;
      ufe_pkg::ST_SZ_B:   state_nxt = ufe_pkg::ST_JOIN;
      ufe_pkg::ST_JOIN:   state_nxt = ufe_pkg::ST_FINISH;
      ufe_pkg::ST_FINISH: begin
        if (res_ready) state_nxt = ufe_pkg::ST_IDLE;
      end
      default: state_nxt = ufe_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    clr_nxt      = clr_r;
    op_nxt       = op_r;
    a_nxt        = a_r;
    b_nxt        = b_r;
    second_nxt   = second_r;
    red_k_nxt    = red_k_r;
    start_nxt    = start_r;
    cur_nxt      = cur_r;
    top_nxt      = top_r;
    ra_nxt       = ra_r;
    size_a_nxt   = size_a_r;
    res_root_nxt = res_root_r;
    joined_nxt   = joined_r;
    res_size_nxt = res_size_r;
    par_we       = 1'b0;
    par_waddr    = cur_r;
    par_wdata    = top_r;
    par_raddr    = cur_r;
    siz_we       = 1'b0;
    siz_waddr    = ra_r;
    siz_wdata    = alu_sum;
    siz_raddr    = ra_r;
    cmd_ready    = 1'b0;
    res_valid    = 1'b0;
    unique case (state_r)
      ufe_pkg::ST_CLEAR: begin
        par_we    = 1'b1;
        par_waddr = clr_r;
        par_wdata = clr_r;
        siz_we    = 1'b1;
        siz_waddr = clr_r;
        siz_wdata = ufe_pkg::SIZE_W'(1);
        clr_nxt   = clr_r + IW'(1);
      end
      ufe_pkg::ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          op_nxt     = cmd.op;
          a_nxt      = cmd.node_a;
          b_nxt      = cmd.node_b;
          second_nxt = 1'b0;
          red_k_nxt  = ufe_pkg::RED_K_W'(ufe_pkg::RED_STEPS - 1);
        end
      end
      ufe_pkg::ST_RED: begin
        if (a_ext >= red_sub) a_nxt = ufe_pkg::NODE_W'(a_ext - red_sub);
        if (b_ext >= red_sub) b_nxt = ufe_pkg::NODE_W'(b_ext - red_sub);
        red_k_nxt = red_k_r - ufe_pkg::RED_K_W'(1);
      end
      ufe_pkg::ST_FIND_START: begin
        start_nxt = start_sel;
        cur_nxt   = start_sel;
        par_raddr = start_sel;
      end
      ufe_pkg::ST_WALK: begin
        if (par_rdata == cur_r) begin
          top_nxt   = cur_r;
          cur_nxt   = start_r;
          par_raddr = start_r;
        end else begin
          cur_nxt   = par_rdata;
          par_raddr = par_rdata;
        end
      end
      ufe_pkg::ST_CMP: begin
        // point cur at the root while fetching the next node up
        par_we = 1'b1;
        if (par_rdata != top_r) begin
          cur_nxt   = par_rdata;
          par_raddr = par_rdata;
        end
      end
      ufe_pkg::ST_NEXT: begin
        if (!second_r) begin
          ra_nxt = top_r;
          if (op_r == ufe_pkg::OP_UNION) second_nxt = 1'b1;
        end
      end
      ufe_pkg::ST_SZ_A: begin
        siz_raddr = ra_r;
      end
      ufe_pkg::ST_SZ_B: begin
        siz_raddr  = top_r;
        size_a_nxt = siz_rdata;
      end
      ufe_pkg::ST_JOIN: begin
        res_root_nxt = ra_r;
        joined_nxt   = 1'b0;
        res_size_nxt = size_a_r;
        if (op_r == ufe_pkg::OP_UNION) begin
          if (ra_r == top_r) begin
            joined_nxt = 1'b1;
          end else if (alu_lt) begin
            par_we       = 1'b1;
            par_waddr    = ra_r;
            par_wdata    = top_r;
            siz_we       = 1'b1;
            siz_waddr    = top_r;
            res_root_nxt = top_r;
            res_size_nxt = alu_sum;
          end else begin
            par_we       = 1'b1;
            par_waddr    = top_r;
            par_wdata    = ra_r;
            siz_we       = 1'b1;
            siz_waddr    = ra_r;
            res_size_nxt = alu_sum;
          end
        end
      end
      ufe_pkg::ST_FINISH: begin
        res_valid = 1'b1;
      end
      default: begin
        cmd_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ufe_pkg::ST_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    second_r   <= second_nxt;
    red_k_r    <= red_k_nxt;
    start_r    <= start_nxt;
    cur_r      <= cur_nxt;
    top_r      <= top_nxt;
    ra_r       <= ra_nxt;
    size_a_r   <= size_a_nxt;
    res_root_r <= res_root_nxt;
    joined_r   <= joined_nxt;
    res_size_r <= res_size_nxt;
  end

  assign res.root           = ufe_pkg::NODE_W'(res_root_r);
  assign res.already_joined = joined_r;
  assign res.set_size       = res_size_r;

`ifndef NO_ASSERTIONS
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ufe_pkg::ST_IDLE) |-> (!par_we && !siz_we))
    else $error("table write while idle");

  a_cmp_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ufe_pkg::ST_CMP && state_nxt == ufe_pkg::ST_CMP) |-> (par_raddr != cur_r))
    else $error("compression reads the entry it rewrites");

  a_join_writes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ufe_pkg::ST_JOIN && op_r == ufe_pkg::OP_UNION && ra_r != top_r)
      |-> (par_we && siz_we && par_waddr != par_wdata))
    else $error("union of distinct roots did not relink");

  a_finish_from_join: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == ufe_pkg::ST_FINISH) |-> ($past(state_r) == ufe_pkg::ST_JOIN))
    else $error("result raised without a merge step");
`endif

endmodule

[src/union_find_engine.sv]
// Top level of the union-find engine: stream ports and result register.
// Depends on ufe_pkg and ufe_ctrl.
//
//   channel | direction | tdata fields (low bit up)
//   in_     | slave     | cmd[0], node_a[10:1], node_b[20:11]
//   out_    | master    | root[9:0], already_joined[10], set_size[21:11]
//
// A find walks from node_a to its root, compresses the path and reads the set
// size; a union walks and compresses for node_a and node_b, reads both root sizes
// and links the smaller set under the larger. Index reduction runs first when
// MAX_NODES is not a power of two below 1024. The parent table's single read port
// walks one node per cycle. After reset a clearing pass over all MAX_NODES entries
// holds in_tready low. One finished result waits in the output register; the next
// item then stalls at its end until that word is taken.
module union_find_engine #(
  parameter int unsigned MAX_NODES = ufe_pkg::MAX_NODES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // cmd, node_a, node_b
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // root, already_joined, set_size
);

  ufe_pkg::ufe_cmd_t    cmd;
  ufe_pkg::ufe_result_t res;
  logic                 res_valid, res_ready;

  logic                 out_valid_r, out_valid_nxt;
  ufe_pkg::ufe_result_t out_data_r, out_data_nxt;

  assign cmd.op     = in_tdata[0];
  assign cmd.node_a = in_tdata[10:1];
  assign cmd.node_b = in_tdata[20:11];

  assign res_ready = !out_valid_r || out_tready;

  ufe_ctrl #(.MAX_NODES(MAX_NODES)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (in_tvalid),
    .cmd_ready (in_tready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_data_r.set_size, out_data_r.already_joined, out_data_r.root};

endmodule

[tb/sv/union_find_engine_tb.sv]
// Self-checking testbench for union_find_engine: find and union words against an
// in-bench disjoint-set predictor with random sender gaps and receiver stalls.
// Depends on ufe_pkg and the union_find_engine RTL.
module union_find_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NODES      = ufe_pkg::MAX_NODES_DEF;
  localparam int unsigned N_RANDOM   = 950;
  localparam int unsigned HOLD_AT    = 300;
  localparam int unsigned HOLD_LEN   = 600;
  localparam int unsigned DRAIN_CYC  = 120;

  typedef struct packed {
    logic [ufe_pkg::NODE_W-1:0] root;
    logic                       joined;
    logic [ufe_pkg::SIZE_W-1:0] size;
  } uf_expect_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // cmd, node_a, node_b
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // root, already_joined, set_size

  union_find_engine dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [ufe_pkg::NODE_W-1:0] parent_of [NODES];
  logic [ufe_pkg::SIZE_W-1:0] size_of   [NODES];

  ufe_pkg::ufe_cmd_t cmd_queue[$];
  uf_expect_t        expected_results[$];

  int unsigned err_count    = 0;
  int unsigned results_seen = 0;
  int unsigned n_find = 0, n_union = 0, n_joined = 0, n_merge = 0;
  int unsigned max_size_seen = 0;

  // walk to the root, then point every visited node straight at it
  function automatic logic [ufe_pkg::NODE_W-1:0] root_of(logic [ufe_pkg::NODE_W-1:0] start);
    logic [ufe_pkg::NODE_W-1:0] top, cur, up;
    int unsigned steps;
    top = start;
    steps = 0;
    while (parent_of[top] != top && steps < NODES) begin
      top = parent_of[top];
      steps++;
    end
    cur = start;
    steps = 0;
    while (cur != top && steps < NODES) begin
      up = parent_of[cur];
      parent_of[cur] = top;
      cur = up;
      steps++;
    end
    return top;
  endfunction

  function automatic uf_expect_t apply_cmd(ufe_pkg::ufe_cmd_t c);
    uf_expect_t r;
    logic [ufe_pkg::NODE_W-1:0] ra, rb;
    ra = root_of(c.node_a);
    r.root = ra;
    r.joined = 1'b0;
    if (c.op == ufe_pkg::OP_UNION) begin
      rb = root_of(c.node_b);
      if (ra == rb) begin
        r.joined = 1'b1;
      end else if (size_of[ra] < size_of[rb]) begin
        size_of[rb] = size_of[rb] + size_of[ra];
        parent_of[ra] = rb;
        r.root = rb;
      end else begin
        size_of[ra] = size_of[ra] + size_of[rb];
        parent_of[rb] = ra;
      end
    end
    r.size = size_of[r.root];
    return r;
  endfunction

  function automatic int unsigned pick_node(int unsigned pool_hi);
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, pool_hi);
    return $urandom_range(0, NODES - 1);
  endfunction

  task automatic add_cmd(logic op, int unsigned a, int unsigned b);
    ufe_pkg::ufe_cmd_t c;
    c.op = op;
    c.node_a = ufe_pkg::NODE_W'(a);
    c.node_b = ufe_pkg::NODE_W'(b);
    cmd_queue.insert(cmd_queue.size(), c);
  endtask

  // driver: bursts with random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk) begin
    ufe_pkg::ufe_cmd_t c;
    uf_expect_t        e;
    logic              nv;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        c.op     = in_tdata[0];
        c.node_a = in_tdata[10:1];
        c.node_b = in_tdata[20:11];
        e = apply_cmd(c);
        expected_results.insert(expected_results.size(), e);
        if (c.op == ufe_pkg::OP_UNION) n_union++;
        else n_find++;
        if (e.joined) n_joined++;
        else if (c.op == ufe_pkg::OP_UNION) n_merge++;
        if (32'(e.size) > max_size_seen) max_size_seen = 32'(e.size);
      end
      if (!in_tvalid || in_tready) begin
        nv = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_queue.size() > 0) begin
          c = cmd_queue.pop_front();
          in_tdata <= {3'b000, c.node_b, c.node_a, c.op};
          nv = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
        in_tvalid <= nv;
      end
    end
  end

  // receiver stall pattern, with one long hold-off to back the block up
  int unsigned rx_mode      = 0;
  int unsigned rx_mode_left = 0;
  int unsigned rx_phase     = 0;
  int unsigned hold_left    = 0;
  bit          hold_done    = 1'b0;

  always @(posedge clk) begin
    logic rdy;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (rx_mode_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(50, 200);
      end else begin
        rx_mode_left--;
      end
      rx_phase++;
      case (rx_mode)
        0: rdy = 1'b1;
        1: rdy = ($urandom_range(0, 3) != 0);
        2: rdy = ((rx_phase % 5) != 0);
        default: rdy = ($urandom_range(0, 2) == 0);
      endcase
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end
      out_tready <= rdy;
    end
  end

  // monitor
  always @(posedge clk) begin
    uf_expect_t e;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen <= results_seen + 1;
      if (expected_results.size() == 0) begin
        $error("unexpected result word %h", out_tdata);
        err_count++;
      end else begin
        e = expected_results.pop_front();
        if (out_tdata[9:0] !== e.root) begin
          $error("root: expected %0d, got %0d", e.root, out_tdata[9:0]);
          err_count++;
        end
        if (out_tdata[10] !== e.joined) begin
          $error("already_joined: expected %0d, got %0d", e.joined, out_tdata[10]);
          err_count++;
        end
        if (out_tdata[21:11] !== e.size) begin
          $error("set_size: expected %0d, got %0d", e.size, out_tdata[21:11]);
          err_count++;
        end
      end
    end
  end

  initial begin
    int unsigned pool_hi;
    for (int i = 0; i < NODES; i++) begin
      parent_of[i] = ufe_pkg::NODE_W'(i);
      size_of[i] = ufe_pkg::SIZE_W'(1);
    end

    // directed: extremes, self-union, ties, smaller-under-larger, deep paths
    add_cmd(ufe_pkg::OP_FIND,  0,    0);
    add_cmd(ufe_pkg::OP_FIND,  1023, 1023);
    add_cmd(ufe_pkg::OP_UNION, 0,    0);
    add_cmd(ufe_pkg::OP_UNION, 0,    1023);
    add_cmd(ufe_pkg::OP_UNION, 1023, 0);
    add_cmd(ufe_pkg::OP_FIND,  1023, 0);
    add_cmd(ufe_pkg::OP_UNION, 5,    6);
    add_cmd(ufe_pkg::OP_UNION, 7,    5);
    add_cmd(ufe_pkg::OP_UNION, 5,    0);
    add_cmd(ufe_pkg::OP_FIND,  1023, 512);
    add_cmd(ufe_pkg::OP_UNION, 1023, 6);
    add_cmd(ufe_pkg::OP_UNION, 512,  511);
    add_cmd(ufe_pkg::OP_UNION, 341,  682);
    add_cmd(ufe_pkg::OP_FIND,  3,    1023);
    add_cmd(ufe_pkg::OP_UNION, 100,  101);
    add_cmd(ufe_pkg::OP_UNION, 102,  103);
    add_cmd(ufe_pkg::OP_UNION, 100,  102);
    add_cmd(ufe_pkg::OP_UNION, 104,  105);
    add_cmd(ufe_pkg::OP_UNION, 106,  107);
    add_cmd(ufe_pkg::OP_UNION, 104,  106);
    add_cmd(ufe_pkg::OP_UNION, 100,  104);
    add_cmd(ufe_pkg::OP_FIND,  107,  0);
    add_cmd(ufe_pkg::OP_FIND,  107,  0);
    add_cmd(ufe_pkg::OP_UNION, 511,  341);
    add_cmd(ufe_pkg::OP_UNION, 682,  1022);

    pool_hi = 15;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 100 == 0) begin
        case ($urandom_range(0, 3))
          0: pool_hi = 15;
          1: pool_hi = 63;
          2: pool_hi = 255;
          default: pool_hi = NODES - 1;
        endcase
      end
      add_cmd(($urandom_range(0, 99) < 55) ? ufe_pkg::OP_UNION : ufe_pkg::OP_FIND,
              pick_node(pool_hi), pick_node(pool_hi));
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    wait (cmd_queue.size() == 0 && !in_tvalid);
    wait (expected_results.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("Covered %0d finds and %0d unions (%0d merges, %0d already joined).",
             n_find, n_union, n_merge, n_joined);
    $display("Largest set reported: %0d elements; results checked: %0d.",
             max_size_seen, results_seen);
    if (err_count == 0) begin
      $display("PASS union_find_engine");
    end else begin
      $display("FAIL union_find_engine");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL union_find_engine");
    $finish;
  end

endmodule
